// ===== sv/tsam_pkg.sv =====
package tsam_pkg;

    localparam int SLOT_COUNT_DEF = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam int SLOT_W = 8;
    localparam int PRESS_W = 16;
    localparam int TEMP_W = 8;
    localparam int BATT_W = 12;
    localparam int ROUND_W = 32;
    localparam int OFFLINE_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 3;

    localparam logic [1:0] ACT_FRAME = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    localparam logic [2:0] ALARM_NONE = 3'd0;
    localparam logic [2:0] ALARM_INVALID = 3'd1;
    localparam logic [2:0] ALARM_PRESS_LOW = 3'd2;
    localparam logic [2:0] ALARM_PRESS_HIGH = 3'd3;
    localparam logic [2:0] ALARM_TEMP_HIGH = 3'd4;
    localparam logic [2:0] ALARM_BATT_LOW = 3'd5;
    localparam logic [2:0] ALARM_OFFLINE = 3'd6;

    localparam logic [CFG_INDEX_W-1:0] CFG_PRESSURE_MIN = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESSURE_MAX = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_MAX = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BATTERY_MIN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFLINE_ROUNDS = 3'd4;

    localparam logic [PRESS_W-1:0] PRESSURE_MIN_RST = 16'd18000;
    localparam logic [PRESS_W-1:0] PRESSURE_MAX_RST = 16'd35000;
    localparam logic [TEMP_W-1:0] TEMP_MAX_RST = 8'd85;
    localparam logic [BATT_W-1:0] BATTERY_MIN_RST = 12'd250;
    localparam logic [OFFLINE_W-1:0] OFFLINE_ROUNDS_RST = 16'd3;

    typedef struct packed {
        logic [PRESS_W-1:0] pressure_min;
        logic [PRESS_W-1:0] pressure_max;
        logic signed [TEMP_W-1:0] temp_max;
        logic [BATT_W-1:0] battery_min;
        logic [OFFLINE_W-1:0] offline_rounds;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic ok;
        logic [SLOT_W-1:0] slot;
        logic valid;
        logic [PRESS_W-1:0] pressure;
        logic signed [TEMP_W-1:0] temperature;
        logic [BATT_W-1:0] battery;
        logic [2:0] alarm;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic [PRESS_W-1:0] pressure;
        logic signed [TEMP_W-1:0] temperature;
        logic [BATT_W-1:0] battery;
        logic [ROUND_W-1:0] last_round;
    } entry_t;

    typedef struct packed {
        logic ok;
        logic [SLOT_W-1:0] slot;
        logic seen;
        logic [2:0] alarm;
        logic valid;
        logic [PRESS_W-1:0] pressure;
        logic signed [TEMP_W-1:0] temperature;
        logic [BATT_W-1:0] battery;
    } result_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SWEEP_RD,
        BK_SWEEP_CHK
    } bk_state_t;

endpackage

// ===== sv/tsam_front.sv =====
module tsam_front
    import tsam_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic                     push,
    input  logic [1:0]               action,
    input  logic [SLOT_W-1:0]        slot,
    input  logic                     frame_valid,
    input  logic [PRESS_W-1:0]       pressure,
    input  logic signed [TEMP_W-1:0] temperature,
    input  logic [BATT_W-1:0]        battery,
    input  cfg_t                     cfg,
    input  logic                     q_full,
    output logic                     q_push,
    output cmd_t                     q_data
);

    logic known;
    logic in_range;
    logic [2:0] alarm_code;

    assign in_range = {1'b0, slot} < 9'(SLOT_COUNT);
    assign known = (action == ACT_FRAME) || (action == ACT_TICK) || (action == ACT_READ);

    // Unused action codes are taken from the port and dropped here.
    assign q_push = push && !q_full && known;

    always_comb
    begin
        priority if (!frame_valid)
        begin
            alarm_code = ALARM_INVALID;
        end
        else if (pressure < cfg.pressure_min)
        begin
            alarm_code = ALARM_PRESS_LOW;
        end
        else if (pressure > cfg.pressure_max)
        begin
            alarm_code = ALARM_PRESS_HIGH;
        end
        else if ($signed(temperature) > $signed(cfg.temp_max))
        begin
            alarm_code = ALARM_TEMP_HIGH;
        end
        else if (battery < cfg.battery_min)
        begin
            alarm_code = ALARM_BATT_LOW;
        end
        else
        begin
            alarm_code = ALARM_NONE;
        end
    end

    always_comb
    begin
        q_data.kind = action;
        q_data.ok = in_range;
        q_data.slot = slot;
        q_data.valid = frame_valid;
        q_data.pressure = pressure;
        q_data.temperature = temperature;
        q_data.battery = battery;
        q_data.alarm = alarm_code;
    end

endmodule

// ===== sv/tsam_queue.sv =====
module tsam_queue
    import tsam_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_push,
    input  cmd_t in_data,
    output logic full,
    input  logic out_pop,
    output cmd_t out_data,
    output logic empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic do_push;
    logic do_pop;

    assign full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = in_push && !full;
    assign do_pop = out_pop && !empty;
    assign out_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= in_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("command queue count exceeds its depth");

    a_full_empty_apart: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("command queue is full and empty at once");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !out_pop) |=> full)
        else $error("command queue left full without a pop");

endmodule

// ===== sv/tsam_back.sv =====
module tsam_back
    import tsam_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    q_empty,
    input  cmd_t    q_data,
    output logic    q_pop,
    output logic    empty,
    input  logic    pop,
    output result_t res
);

    localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    bk_state_t state_reg;
    bk_state_t state_next;

    logic [ROUND_W-1:0] round_reg;
    logic [SLOT_COUNT-1:0] seen_reg;
    logic [SLOT_AW-1:0] idx_reg;
    logic [SLOT_AW-1:0] idx_next;
    logic [SLOT_W-1:0] slot_reg;
    logic out_valid_reg;
    result_t result_reg;

    entry_t mem_entry [SLOT_COUNT];
    logic [2:0] mem_alarm [SLOT_COUNT];
    entry_t rd_entry_reg;
    logic [2:0] rd_alarm_reg;

    logic out_free;
    logic tick_pop;
    logic read_pop;
    logic frame_pop;
    logic out_load;
    result_t out_data;
    logic [SLOT_AW-1:0] head_idx;
    logic [SLOT_AW-1:0] slot_idx;
    logic [SLOT_AW-1:0] rd_addr;
    logic ent_we;
    entry_t ent_wdata;
    logic alarm_we;
    logic [SLOT_AW-1:0] alarm_waddr;
    logic [2:0] alarm_wdata;
    logic [ROUND_W-1:0] age;
    logic sweep_last;

    assign out_free = !out_valid_reg || pop;
    assign head_idx = q_data.slot[SLOT_AW-1:0];
    assign slot_idx = slot_reg[SLOT_AW-1:0];
    assign age = round_reg - rd_entry_reg.last_round;
    assign sweep_last = (idx_reg == SLOT_AW'(SLOT_COUNT - 1));
    assign empty = !out_valid_reg;
    assign res = result_reg;

    always_comb
    begin
        q_pop = 1'b0;
        tick_pop = 1'b0;
        read_pop = 1'b0;
        frame_pop = 1'b0;
        out_load = 1'b0;
        out_data = '0;
        rd_addr = idx_reg;
        ent_we = 1'b0;
        ent_wdata.valid = q_data.valid;
        ent_wdata.pressure = q_data.pressure;
        ent_wdata.temperature = q_data.temperature;
        ent_wdata.battery = q_data.battery;
        ent_wdata.last_round = round_reg;
        alarm_we = 1'b0;
        alarm_waddr = idx_reg;
        alarm_wdata = ALARM_OFFLINE;
        idx_next = idx_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                rd_addr = head_idx;
                if (!q_empty)
                begin
                    if (q_data.kind == ACT_TICK)
                    begin
                        q_pop = 1'b1;
                        tick_pop = 1'b1;
                        idx_next = '0;
                    end
                    else if (out_free)
                    begin
                        q_pop = 1'b1;
                        out_data.slot = q_data.slot;
                        if (q_data.ok && (q_data.kind == ACT_READ))
                        begin
                            read_pop = 1'b1;
                        end
                        else
                        begin
                            out_load = 1'b1;
                            if (q_data.ok)
                            begin
                                frame_pop = 1'b1;
                                ent_we = 1'b1;
                                alarm_we = 1'b1;
                                alarm_waddr = head_idx;
                                alarm_wdata = q_data.alarm;
                                out_data.ok = 1'b1;
                                out_data.seen = 1'b1;
                                out_data.alarm = q_data.alarm;
                                out_data.valid = q_data.valid;
                                out_data.pressure = q_data.pressure;
                                out_data.temperature = q_data.temperature;
                                out_data.battery = q_data.battery;
                            end
                        end
                    end
                end
            end
            BK_READ:
            begin
                out_load = 1'b1;
                out_data.ok = 1'b1;
                out_data.slot = slot_reg;
                if (seen_reg[slot_idx])
                begin
                    out_data.seen = 1'b1;
                    out_data.alarm = rd_alarm_reg;
                    out_data.valid = rd_entry_reg.valid;
                    out_data.pressure = rd_entry_reg.pressure;
                    out_data.temperature = rd_entry_reg.temperature;
                    out_data.battery = rd_entry_reg.battery;
                end
            end
            BK_SWEEP_RD:
            begin
                rd_addr = idx_reg;
            end
            BK_SWEEP_CHK:
            begin
                alarm_we = seen_reg[idx_reg] && (age >= {16'd0, cfg.offline_rounds});
                idx_next = idx_reg + 1'b1;
            end
            default:
            begin
                rd_addr = idx_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (tick_pop)
                begin
                    state_next = BK_SWEEP_RD;
                end
                else if (read_pop)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_IDLE;
            end
            BK_SWEEP_RD:
            begin
                state_next = BK_SWEEP_CHK;
            end
            BK_SWEEP_CHK:
            begin
                state_next = sweep_last ? BK_IDLE : BK_SWEEP_RD;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            round_reg <= '0;
            seen_reg <= '0;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            if (tick_pop)
            begin
                round_reg <= round_reg + 1'b1;
            end
            if (frame_pop)
            begin
                seen_reg[head_idx] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            slot_reg <= q_data.slot;
        end
        if (out_load)
        begin
            result_reg <= out_data;
        end
    end

    // Slot table: one write port per array, one shared registered read port.
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            mem_entry[head_idx] <= ent_wdata;
        end
        if (alarm_we)
        begin
            mem_alarm[alarm_waddr] <= alarm_wdata;
        end
        rd_entry_reg <= mem_entry[rd_addr];
        rd_alarm_reg <= mem_alarm[rd_addr];
    end

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_IDLE) |-> !q_pop)
        else $error("command taken while the back end is busy");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || pop))
        else $error("result register overwritten before it was taken");

    a_tick_round: assert property (@(posedge clk) disable iff (!rst_n)
        tick_pop |=> (round_reg == $past(round_reg) + 1'b1))
        else $error("round counter did not advance on a tick");

endmodule

// ===== sv/tire_sensor_alarm_monitor.sv =====
// Tire sensor alarm monitor.
// Requests enter through a queue-style port: drive the fields and raise push;
// the request is taken at a clock edge where push is high and full is low.
// Results leave the same way: while empty is low the oldest result sits on
// the result ports, and it is taken at an edge where pop is high.
// Frame and read requests give one result each; a tick gives none.
// A two-entry command queue separates the classifier from the slot table.
// A frame or an out-of-range request passes through the queue and the output
// register; a read also passes through BK_READ and the table's registered read
// port. A tick occupies the table while the aging sweep reads and checks one
// slot at a time through the table's single read port.
// When the result consumer stalls, one finished result waits in the output
// register, the queue keeps filling, and full rises once it holds two
// transactions; a tick at the head of the queue still drains during the stall.
// Reset clears the round counter, every slot's data flag, the queue and the
// output register, and loads the threshold registers with their defaults.
// Thresholds must be written through wr_en, wr_index and wr_data while idle; the block does not enforce it.
module tire_sensor_alarm_monitor
    import tsam_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [1:0]               action,
    input  logic [SLOT_W-1:0]        slot,
    input  logic                     frame_valid,
    input  logic [PRESS_W-1:0]       pressure,
    input  logic signed [TEMP_W-1:0] temperature,
    input  logic [BATT_W-1:0]        battery,
    output logic                     empty,
    input  logic                     pop,
    output logic                     ok,
    output logic [SLOT_W-1:0]        out_slot,
    output logic                     data_seen,
    output logic [2:0]               alarm,
    output logic                     last_valid,
    output logic [PRESS_W-1:0]       last_pressure,
    output logic signed [TEMP_W-1:0] last_temperature,
    output logic [BATT_W-1:0]        last_battery,
    input  logic                     wr_en,
    input  logic [CFG_INDEX_W-1:0]   wr_index,
    input  logic [CFG_DATA_W-1:0]    wr_data
);

    cfg_t cfg_reg;
    logic q_push;
    cmd_t q_in;
    logic q_full;
    logic q_pop;
    cmd_t q_head;
    logic q_empty;
    result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pressure_min <= PRESSURE_MIN_RST;
            cfg_reg.pressure_max <= PRESSURE_MAX_RST;
            cfg_reg.temp_max <= TEMP_MAX_RST;
            cfg_reg.battery_min <= BATTERY_MIN_RST;
            cfg_reg.offline_rounds <= OFFLINE_ROUNDS_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_PRESSURE_MIN:   cfg_reg.pressure_min <= wr_data;
                CFG_PRESSURE_MAX:   cfg_reg.pressure_max <= wr_data;
                CFG_TEMP_MAX:       cfg_reg.temp_max <= wr_data[TEMP_W-1:0];
                CFG_BATTERY_MIN:    cfg_reg.battery_min <= wr_data[BATT_W-1:0];
                CFG_OFFLINE_ROUNDS: cfg_reg.offline_rounds <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    assign full = q_full;

    tsam_front #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_front (
        .push(push),
        .action(action),
        .slot(slot),
        .frame_valid(frame_valid),
        .pressure(pressure),
        .temperature(temperature),
        .battery(battery),
        .cfg(cfg_reg),
        .q_full(q_full),
        .q_push(q_push),
        .q_data(q_in)
    );

    tsam_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .in_push(q_push),
        .in_data(q_in),
        .full(q_full),
        .out_pop(q_pop),
        .out_data(q_head),
        .empty(q_empty)
    );

    tsam_back #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .q_empty(q_empty),
        .q_data(q_head),
        .q_pop(q_pop),
        .empty(empty),
        .pop(pop),
        .res(res)
    );

    assign ok = res.ok;
    assign out_slot = res.slot;
    assign data_seen = res.seen;
    assign alarm = res.alarm;
    assign last_valid = res.valid;
    assign last_pressure = res.pressure;
    assign last_temperature = res.temperature;
    assign last_battery = res.battery;

endmodule
